// File: src/bffl_pkg.sv
// ----------------------------------------------------------------------------
// bffl_pkg
// Shared types, constants and helpers for the free-list allocator.
// ----------------------------------------------------------------------------
package bffl_pkg;

    localparam int FREE_ENTRIES_DEF = 32;
    localparam int ADDR_BITS_DEF    = 24;
    localparam int ALIGN_BYTES_DEF  = 4;
    localparam int HEADER_BYTES_DEF = 4;
    localparam int MIN_BLOCK_DEF    = 8;

    localparam int FIELD_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd2;

    localparam logic       ACT_ALLOC = 1'b0;
    localparam logic       ACT_FREE  = 1'b1;
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_HEAP_FULL  = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic                action;
        logic [FIELD_W-1:0]  req_size;
        logic [FIELD_W-1:0]  user_addr;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0]  result_addr;
        logic [1:0]          status;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_SHIFT,
        S_SPLIT,
        S_DONE
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // latch the input item
        logic scan_start; // set scan pointer to the newest entry
        logic scan_step;  // evaluate one entry, move to the older one
        logic rd_pick;    // read the picked entry
        logic shift_step; // move one entry down during removal
        logic push_split; // push the remainder
        logic do_free;    // push the freed block
        logic do_bump;    // carve at heap top
        logic finish;     // load output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_free;
        logic table_full;
        logic scan_done;  // no entry left or first-fit/exact hit
        logic found;
        logic shift_done;
        logic need_split;
    } dp_stat_t;

endpackage

// File: src/best_fit_free_list_allocator.sv
// Sequence: a free is taken, pushed onto the table if it is not full and registered as the
// result; an alloc scans the entries newest first, reads the picked entry, moves each later
// entry down on removal (a read, then a write), pushes a split remainder and registers the result.
// One item at a time: a new item is taken only after the last result is registered.
// The one-entry-per-cycle table read port sets the rate; a stalled result holds the input.
// Reset clears the free count, the heap top and the control registers; table contents and payload registers stay.
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator
// Top level: controller, datapath and output register.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator
    import bffl_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MIN_BLOCK    = MIN_BLOCK_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data
);

    dp_cmd_t   cmd;
    dp_stat_t  stat;
    out_item_t res;
    logic      out_valid_reg;
    out_item_t out_data_reg;

    bffl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_busy (out_valid_reg && !out_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bffl_dp #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .ADDR_BITS    (ADDR_BITS),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MIN_BLOCK    (MIN_BLOCK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_item  (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && !out_ready))
        else $error("result overwrote a pending transfer");
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.do_free, cmd.do_bump, cmd.push_split, cmd.rd_pick}))
        else $error("conflicting datapath commands");
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result not presented");
`endif

endmodule

// File: src/bffl_ctrl.sv
// ----------------------------------------------------------------------------
// bffl_ctrl
// Sequencer: scan, read, shift-remove, split push, result.
// ----------------------------------------------------------------------------
module bffl_ctrl
    import bffl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.is_free)
                begin
                    state_next = S_DONE;
                    if (!stat.table_full)
                        cmd.do_free = 1'b1;
                end
                else if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        cmd.rd_pick = 1'b1;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        cmd.do_bump = 1'b1;
                        state_next  = S_DONE;
                    end
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_READ:
                state_next = S_SHIFT;
            S_SHIFT:
            begin
                if (stat.shift_done)
                    state_next = stat.need_split ? S_SPLIT : S_DONE;
                else
                    cmd.shift_step = 1'b1;
            end
            S_SPLIT:
            begin
                cmd.push_split = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: src/bffl_dp.sv
// ----------------------------------------------------------------------------
// bffl_dp
// Free table memory, scan pointer, best-fit tracking, heap top, result.
// ----------------------------------------------------------------------------
module bffl_dp
    import bffl_pkg::*;
#(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MIN_BLOCK    = MIN_BLOCK_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]  cfg_data,
    input  in_item_t            in_item,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output out_item_t           res_item
);

    localparam int IDX_W = $clog2(FREE_ENTRIES);
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam int HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int MINSZ = ((MIN_BLOCK + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int W     = FIELD_W + 8;  // wide enough for sums without overflow
    localparam logic [W-1:0] ADDR_MAX = W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [W-1:0] HDR_W    = W'(HDR);
    localparam logic [W-1:0] MINSZ_W  = W'(MINSZ);
    localparam logic [W-1:0] SPLIT_MIN = W'(2 * MINSZ + HDR);
    localparam logic [W-1:0] ALIGN_M1 = W'(ALIGN_BYTES - 1);

    // Free table: one write port, one read port, registered read
    logic [ADDR_BITS-1:0] addr_mem [FREE_ENTRIES];
    logic [FIELD_W-1:0]   size_mem [FREE_ENTRIES];
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [FIELD_W-1:0]   wr_size;
    logic [IDX_W-1:0]     rd_idx;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic [FIELD_W-1:0]   rd_size_reg;

    // Configuration and control registers
    logic [FIELD_W-1:0]   heap_limit_reg;
    logic                 fit_mode_reg;
    logic [ADDR_BITS-1:0] heap_top_reg;
    logic [CNT_W-1:0]     count_reg;
    in_item_t             item_reg;
    logic [W-1:0]         size_reg;      // rounded request
    logic [CNT_W-1:0]     ptr_reg;       // entries left to scan
    logic                 rd_ok_reg;     // read data valid for ptr_reg
    logic                 found_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [FIELD_W-1:0]   best_reg;
    logic [IDX_W-1:0]     sh_reg;        // removal shift position
    logic                 sh_phase_reg;  // 0 read issued, 1 data ready
    logic [ADDR_BITS-1:0] blk_addr_reg;
    logic [FIELD_W-1:0]   blk_size_reg;
    out_item_t            res_reg;

    logic [W-1:0] rounded;
    logic [W-1:0] cur_size;
    logic         fits;
    logic         take;
    logic [W-1:0] bump_size;
    logic [W-1:0] new_top;
    logic         heap_full;
    logic [W-1:0] split_size;
    logic [W-1:0] split_addr;

    assign rounded  = (W'(in_item.req_size) + ALIGN_M1) & ~ALIGN_M1;
    assign cur_size = W'(rd_size_reg);
    assign fits     = rd_ok_reg && (cur_size >= size_reg);
    assign take     = fits && (fit_mode_reg || cur_size == size_reg
                      || !found_reg || rd_size_reg < best_reg);

    assign bump_size = (size_reg < MINSZ_W) ? MINSZ_W : size_reg;
    assign new_top   = W'(heap_top_reg) + HDR_W + bump_size;
    assign heap_full = ((heap_limit_reg != '0) && new_top > W'(heap_limit_reg))
                       || new_top > ADDR_MAX;
    assign split_size = W'(blk_size_reg) - (size_reg + HDR_W);
    assign split_addr = W'(blk_addr_reg) + HDR_W + size_reg;

    // Status to controller
    always_comb
    begin
        stat.is_free    = (item_reg.action == ACT_FREE);
        stat.table_full = (count_reg == CNT_W'(FREE_ENTRIES));
        stat.scan_done  = rd_ok_reg ? (take && (fit_mode_reg || cur_size == size_reg))
                                      || (ptr_reg == '0) || hit_reg
                                    : (ptr_reg == '0) || hit_reg;
        stat.found      = found_reg || take;
        stat.shift_done = (CNT_W'(sh_reg) >= count_reg) && !sh_phase_reg;
        stat.need_split = (W'(blk_size_reg) > (size_reg << 1) + HDR_W)
                          && (W'(blk_size_reg) > SPLIT_MIN);
    end

    // Read address select
    always_comb
    begin
        rd_idx = ptr_reg[IDX_W-1:0] - IDX_W'(1);
        if (cmd.rd_pick)
            rd_idx = take ? IDX_W'(ptr_reg) : pick_reg;
        else if (cmd.shift_step || sh_phase_reg)
            rd_idx = sh_reg + IDX_W'(1);
        if (cmd.scan_start)
            rd_idx = IDX_W'(count_reg - CNT_W'(1));
    end

    // Write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = count_reg[IDX_W-1:0];
        wr_addr = item_reg.user_addr[ADDR_BITS-1:0] - ADDR_BITS'(HDR);
        wr_size = item_reg.req_size;
        if (cmd.do_free)
            wr_en = 1'b1;
        else if (cmd.push_split)
        begin
            wr_en   = 1'b1;
            wr_addr = split_addr[ADDR_BITS-1:0];
            wr_size = split_size[FIELD_W-1:0];
        end
        else if (cmd.shift_step && sh_phase_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = sh_reg;
            wr_addr = rd_addr_reg;
            wr_size = rd_size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_mem[wr_idx] <= wr_addr;
            size_mem[wr_idx] <= wr_size;
        end
        rd_addr_reg <= addr_mem[rd_idx];
        rd_size_reg <= size_mem[rd_idx];
    end

    // In the cycle after rd_pick the picked entry is on the read register
    logic rd_pick_d_reg;
    logic state_read_capture;
    assign state_read_capture = rd_pick_d_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
            size_reg <= rounded;
        end
        if (cmd.scan_step && take)
        begin
            pick_reg <= IDX_W'(ptr_reg);
            best_reg <= rd_size_reg;
        end
        if (state_read_capture)
        begin
            blk_addr_reg <= rd_addr_reg;
            blk_size_reg <= rd_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_limit_reg <= '0;
            fit_mode_reg   <= 1'b0;
            heap_top_reg   <= '0;
            count_reg      <= '0;
            ptr_reg        <= '0;
            rd_ok_reg      <= 1'b0;
            found_reg      <= 1'b0;
            hit_reg        <= 1'b0;
            sh_reg         <= '0;
            sh_phase_reg   <= 1'b0;
            rd_pick_d_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            rd_pick_d_reg <= cmd.rd_pick;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEAP_START: heap_top_reg   <= cfg_data[ADDR_BITS-1:0];
                    CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    CFG_FIT_MODE:   fit_mode_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.scan_start)
            begin
                ptr_reg   <= count_reg;
                rd_ok_reg <= 1'b0;
                found_reg <= 1'b0;
                hit_reg   <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                // first step only issues the read of the newest entry
                if (rd_ok_reg)
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                        if (fit_mode_reg || cur_size == size_reg)
                            hit_reg <= 1'b1;
                    end
                end
                if (!hit_reg && !(take && (fit_mode_reg || cur_size == size_reg)))
                begin
                    ptr_reg   <= ptr_reg - CNT_W'(1);
                    rd_ok_reg <= (ptr_reg != '0);
                end
            end
            if (cmd.rd_pick)
            begin
                sh_reg       <= take ? IDX_W'(ptr_reg) : pick_reg;
                sh_phase_reg <= 1'b1;
                count_reg    <= count_reg - CNT_W'(1);
            end
            else if (cmd.shift_step)
            begin
                if (sh_phase_reg)
                    sh_reg <= sh_reg + IDX_W'(1);
                sh_phase_reg <= !sh_phase_reg;
            end
            else if (sh_phase_reg && rd_pick_d_reg)
                sh_phase_reg <= 1'b0;
            if (cmd.do_free || cmd.push_split)
                count_reg <= count_reg + CNT_W'(1);
            if (cmd.do_bump && !heap_full)
                heap_top_reg <= new_top[ADDR_BITS-1:0];
            // A free into a full table is flagged when the item is taken
            if (cmd.do_bump)
            begin
                res_reg.status      <= heap_full ? ST_HEAP_FULL : ST_OK;
                res_reg.result_addr <= heap_full ? '0
                    : FIELD_W'(heap_top_reg + ADDR_BITS'(HDR));
            end
            else if (cmd.load)
            begin
                res_reg.result_addr <= '0;
                res_reg.status      <= (in_item.action == ACT_FREE
                                        && count_reg == CNT_W'(FREE_ENTRIES))
                                       ? ST_TABLE_FULL : ST_OK;
            end
            if (rd_pick_d_reg)
                res_reg.result_addr <= FIELD_W'(rd_addr_reg + ADDR_BITS'(HDR));
        end
    end

    assign res_item = res_reg;

endmodule
